// ===== hw/rtl/rrt_pkg.sv =====
`default_nettype none

package rrt_pkg;

  // Input func codes
  localparam logic [1:0] FN_TICK = 2'd0;
  localparam logic [1:0] FN_SEND = 2'd1;
  localparam logic [1:0] FN_ACK  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_TIMEOUT = 2'd0;
  localparam logic [1:0] REG_MAXRETX = 2'd1;
  localparam logic [1:0] REG_WARMUP  = 2'd2;

  // Event kinds
  localparam logic [2:0] EV_SENT    = 3'd0;
  localparam logic [2:0] EV_RETX    = 3'd1;
  localparam logic [2:0] EV_DONE    = 3'd2;
  localparam logic [2:0] EV_ABANDON = 3'd3;
  localparam logic [2:0] EV_DUP     = 3'd4;
  localparam logic [2:0] EV_FULL    = 3'd5;

  // Statistics counter slots
  localparam int NUM_CNT = 5;
  localparam logic [2:0] CNT_SENT    = 3'd0;
  localparam logic [2:0] CNT_RETX    = 3'd1;
  localparam logic [2:0] CNT_ACKED   = 3'd2;
  localparam logic [2:0] CNT_ABANDON = 3'd3;
  localparam logic [2:0] CNT_DUP     = 3'd4;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_LOAD,
    OP_CLEAR,
    OP_RETX
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     advance;
  } cell_ctl_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] ack_seq;
  } req_t;

  typedef struct packed {
    logic [2:0]  event_kind;
    logic [15:0] seq_number;
    logic [8:0]  transmissions;
    logic [31:0] completion_delay;
    logic        last;
    logic [31:0] sent_count;
    logic [31:0] retransmit_count;
    logic [31:0] acked_count;
    logic [31:0] abandoned_count;
    logic [31:0] duplicate_count;
  } rsp_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [31:0] value;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrt_req_if.sv =====
`default_nettype none

interface rrt_req_if;
  logic          valid;
  logic          ready;
  rrt_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rrt_rsp_if.sv =====
`default_nettype none

interface rrt_rsp_if;
  logic          valid;
  logic          ready;
  rrt_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rrt_cfg_if.sv =====
`default_nettype none

interface rrt_cfg_if;
  logic          valid;
  logic          ready;
  rrt_pkg::cfg_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rrt_cell.sv =====
`default_nettype none

module rrt_cell #(
  parameter int SEQ_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire rrt_pkg::cell_ctl_t   ctl,
  input  wire logic                 sel,
  input  wire logic [SEQ_BITS-1:0]  wr_seq,
  input  wire logic [SEQ_BITS-1:0]  key,
  input  wire logic [TIME_BITS-1:0] cur_time,
  input  wire logic [TIME_BITS-1:0] new_deadline,
  input  wire logic                 tok_in,
  input  wire logic                 after_in,
  output logic                      tok,
  output logic                      after_out,
  output logic                      tok_hit,
  output logic                      tok_later,
  output logic                      match,
  output logic                      valid,
  output logic [SEQ_BITS-1:0]       seq,
  output logic [TIME_BITS-1:0]      first_sent,
  output logic [8:0]                tx_count
);

  logic [TIME_BITS-1:0] deadline;
  logic                 expired;

  assign expired   = valid && (deadline == cur_time);
  assign after_out = after_in | expired;
  assign tok_hit   = tok & expired;
  assign tok_later = tok & after_in;
  assign match     = valid && (seq == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= 1'b0;
    end else begin
      if (ctl.advance) tok <= tok_in;
      if (sel) begin
        case (ctl.op)
          rrt_pkg::OP_LOAD:  valid <= 1'b1;
          rrt_pkg::OP_CLEAR: valid <= 1'b0;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel) begin
      case (ctl.op)
        rrt_pkg::OP_LOAD: begin
          seq        <= wr_seq;
          first_sent <= cur_time;
          deadline   <= new_deadline;
          tx_count   <= 9'd1;
        end
        rrt_pkg::OP_RETX: begin
          tx_count <= tx_count + 9'd1;
          deadline <= new_deadline;
        end
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/retransmit_request_tracker.sv =====
`default_nettype none

// Channel  Dir  Contents                                       Transaction
// -------  ---  ---------------------------------------------  ------------------------
// cfg      in   index (2b), value (32b)                        valid && ready, ready = 1
// req      in   func (2b), ack_seq (16b)                       valid && ready
// rsp      out  event, seq, tx count, delay, last, 5 counters  valid && ready
//
// Send and ack items are accepted, then looked up over the cell row in ST_LOOK.
// A tick advances time, then ST_SCAN_START checks for an expired entry; if any, a scan token walks
// the cell row one cell per cycle unless the output stalls it, and emits one result per expired cell.
// A waiting result in the output register stalls the lookup or scan step that needs it.
// Reset (rst, synchronous) clears entry valid bits, time, sequence and counters, and restores config defaults.

module retransmit_request_tracker #(
  parameter int TABLE_DEPTH = 16,
  parameter int SEQ_BITS    = 16,
  parameter int TIME_BITS   = 32
) (
  input  wire logic   clk,
  input  wire logic   rst,
  rrt_cfg_if.sink     cfg,
  rrt_req_if.sink     req,
  rrt_rsp_if.source   rsp
);

  localparam int CMP_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SCAN_START,
    ST_SCAN
  } state_t;

  state_t state;

  // Configuration
  logic [15:0] timeout_ticks;
  logic [7:0]  max_retx;
  logic [31:0] warmup_ticks;

  // Block state
  logic [TIME_BITS-1:0] cur_time;
  logic [SEQ_BITS-1:0]  next_seq;
  logic [31:0]          cnt      [rrt_pkg::NUM_CNT];
  logic [31:0]          cnt_next [rrt_pkg::NUM_CNT];
  logic [1:0]           func_q;
  logic [15:0]          ack_q;

  // Output register
  logic          out_valid;
  rrt_pkg::rsp_t out_data;

  // Cell row
  rrt_pkg::cell_ctl_t   ctl;
  logic                 head;
  logic [TABLE_DEPTH-1:0] sel, tok, after_out, tok_hit, tok_later, match, valid;
  logic [SEQ_BITS-1:0]  c_seq   [TABLE_DEPTH];
  logic [TIME_BITS-1:0] c_first [TABLE_DEPTH];
  logic [8:0]           c_tx    [TABLE_DEPTH];
  logic [SEQ_BITS-1:0]  key;
  logic [TIME_BITS-1:0] new_deadline;

  // Decision
  logic [TABLE_DEPTH-1:0] msel, fsel, rd_sel;
  logic                   mfound, ffound;
  logic [SEQ_BITS-1:0]    rd_seq;
  logic [TIME_BITS-1:0]   rd_first;
  logic [8:0]             rd_tx;
  logic                   out_free, emit, ev_last, warm_now, warm_first;
  logic [2:0]             ev_kind;
  logic [SEQ_BITS-1:0]    ev_seq;
  logic [8:0]             ev_tx;
  logic [31:0]            ev_delay;
  logic                   do_bump;
  logic [2:0]             bump_idx;
  logic                   scan_done;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign out_free = !out_valid || rsp.ready;
  assign key      = (func_q == rrt_pkg::FN_SEND) ? next_seq : SEQ_BITS'(ack_q);
  // Zero timeout acts as one tick.
  assign new_deadline = cur_time + TIME_BITS'((timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks);

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      logic tin, ain;
      if (gi == 0) begin : g_head
        assign tin = head;
      end else begin : g_mid
        assign tin = tok[gi-1];
      end
      if (gi == TABLE_DEPTH - 1) begin : g_tail
        assign ain = 1'b0;
      end else begin : g_body
        assign ain = after_out[gi+1];
      end
      rrt_cell #(.SEQ_BITS(SEQ_BITS), .TIME_BITS(TIME_BITS)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .ctl          (ctl),
        .sel          (sel[gi]),
        .wr_seq       (next_seq),
        .key          (key),
        .cur_time     (cur_time),
        .new_deadline (new_deadline),
        .tok_in       (tin),
        .after_in     (ain),
        .tok          (tok[gi]),
        .after_out    (after_out[gi]),
        .tok_hit      (tok_hit[gi]),
        .tok_later    (tok_later[gi]),
        .match        (match[gi]),
        .valid        (valid[gi]),
        .seq          (c_seq[gi]),
        .first_sent   (c_first[gi]),
        .tx_count     (c_tx[gi])
      );
    end
  endgenerate

  // Lowest matching slot and lowest free slot.
  always_comb begin
    msel   = '0;
    fsel   = '0;
    mfound = 1'b0;
    ffound = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (match[i] && !mfound) begin
        msel[i] = 1'b1;
        mfound  = 1'b1;
      end
      if (!valid[i] && !ffound) begin
        fsel[i] = 1'b1;
        ffound  = 1'b1;
      end
    end
  end

  // Read the selected cell.
  assign rd_sel = (state == ST_SCAN) ? tok : msel;
  always_comb begin
    rd_seq   = '0;
    rd_first = '0;
    rd_tx    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (rd_sel[i]) begin
        rd_seq   = rd_seq | c_seq[i];
        rd_first = rd_first | c_first[i];
        rd_tx    = rd_tx | c_tx[i];
      end
    end
  end

  assign warm_now   = CMP_BITS'(cur_time) >= CMP_BITS'(warmup_ticks);
  assign warm_first = CMP_BITS'(rd_first) >= CMP_BITS'(warmup_ticks);

  always_comb begin
    ctl.op      = rrt_pkg::OP_NONE;
    ctl.advance = 1'b0;
    head        = 1'b0;
    sel         = '0;
    emit        = 1'b0;
    ev_last     = 1'b1;
    ev_kind     = rrt_pkg::EV_SENT;
    ev_seq      = rd_seq;
    ev_tx       = '0;
    ev_delay    = '0;
    do_bump     = 1'b0;
    bump_idx    = rrt_pkg::CNT_SENT;
    case (state)
      ST_LOOK: begin
        if (out_free) begin
          emit = 1'b1;
          if (func_q == rrt_pkg::FN_SEND) begin
            ev_seq = next_seq;
            if (mfound || ffound) begin
              // Reuse a slot holding this number, else take the lowest free one.
              sel      = mfound ? msel : fsel;
              ctl.op   = rrt_pkg::OP_LOAD;
              ev_kind  = rrt_pkg::EV_SENT;
              ev_tx    = 9'd1;
              do_bump  = warm_now;
              bump_idx = rrt_pkg::CNT_SENT;
            end else begin
              ev_kind = rrt_pkg::EV_FULL;
            end
          end else begin
            if (mfound) begin
              sel      = msel;
              ctl.op   = rrt_pkg::OP_CLEAR;
              ev_kind  = rrt_pkg::EV_DONE;
              ev_tx    = rd_tx;
              ev_delay = 32'(cur_time - rd_first);
              do_bump  = warm_first;
              bump_idx = rrt_pkg::CNT_ACKED;
            end else begin
              ev_kind  = rrt_pkg::EV_DUP;
              ev_seq   = SEQ_BITS'(ack_q);
              do_bump  = 1'b1;
              bump_idx = rrt_pkg::CNT_DUP;
            end
          end
        end
      end
      ST_SCAN_START: begin
        // Inject the token only when some entry expires at this tick.
        if (after_out[0]) begin
          ctl.advance = 1'b1;
          head        = 1'b1;
        end
      end
      ST_SCAN: begin
        if (|tok_hit) begin
          if (out_free) begin
            emit        = 1'b1;
            ctl.advance = 1'b1;
            sel         = tok;
            ev_last     = !(|tok_later);
            do_bump     = warm_now;
            if (rd_tx > {1'b0, max_retx}) begin
              ctl.op   = rrt_pkg::OP_CLEAR;
              ev_kind  = rrt_pkg::EV_ABANDON;
              ev_tx    = rd_tx;
              bump_idx = rrt_pkg::CNT_ABANDON;
            end else begin
              ctl.op   = rrt_pkg::OP_RETX;
              ev_kind  = rrt_pkg::EV_RETX;
              ev_tx    = rd_tx + 9'd1;
              bump_idx = rrt_pkg::CNT_RETX;
            end
          end
        end else begin
          ctl.advance = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign scan_done = ctl.advance && tok[TABLE_DEPTH-1];

  // Saturating counters.
  always_comb begin
    for (int i = 0; i < rrt_pkg::NUM_CNT; i++) begin
      cnt_next[i] = cnt[i];
      if (do_bump && (bump_idx == 3'(i)) && (cnt[i] != 32'hFFFF_FFFF))
        cnt_next[i] = cnt[i] + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      timeout_ticks <= 16'd1000;
      max_retx      <= 8'd3;
      warmup_ticks  <= 32'd0;
      cur_time      <= '0;
      next_seq      <= '0;
      out_valid     <= 1'b0;
      for (int i = 0; i < rrt_pkg::NUM_CNT; i++) cnt[i] <= '0;
    end else begin
      if (cfg.valid) begin
        case (cfg.data.index)
          rrt_pkg::REG_TIMEOUT: timeout_ticks <= cfg.data.value[15:0];
          rrt_pkg::REG_MAXRETX: max_retx      <= cfg.data.value[7:0];
          rrt_pkg::REG_WARMUP:  warmup_ticks  <= cfg.data.value;
          default: ;
        endcase
      end

      for (int i = 0; i < rrt_pkg::NUM_CNT; i++) cnt[i] <= cnt_next[i];

      // Hold a result until taken; load a fresh one on emit.
      if (emit) begin
        out_valid                 <= 1'b1;
        out_data.event_kind       <= ev_kind;
        out_data.seq_number       <= 16'(ev_seq);
        out_data.transmissions    <= ev_tx;
        out_data.completion_delay <= ev_delay;
        out_data.last             <= ev_last;
        out_data.sent_count       <= cnt_next[rrt_pkg::CNT_SENT];
        out_data.retransmit_count <= cnt_next[rrt_pkg::CNT_RETX];
        out_data.acked_count      <= cnt_next[rrt_pkg::CNT_ACKED];
        out_data.abandoned_count  <= cnt_next[rrt_pkg::CNT_ABANDON];
        out_data.duplicate_count  <= cnt_next[rrt_pkg::CNT_DUP];
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            func_q <= req.data.func;
            ack_q  <= req.data.ack_seq;
            case (req.data.func)
              rrt_pkg::FN_TICK: begin
                cur_time <= cur_time + 1'b1;
                state    <= ST_SCAN_START;
              end
              rrt_pkg::FN_SEND: state <= ST_LOOK;
              rrt_pkg::FN_ACK:  state <= ST_LOOK;
              default: ;
            endcase
          end
        end
        ST_LOOK: begin
          if (out_free) begin
            if (func_q == rrt_pkg::FN_SEND && (mfound || ffound))
              next_seq <= next_seq + 1'b1;
            state <= ST_IDLE;
          end
        end
        ST_SCAN_START: state <= after_out[0] ? ST_SCAN : ST_IDLE;
        ST_SCAN: begin
          if (scan_done) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
